// ===== sv/mprc_pkg.sv =====
package mprc_pkg;

  localparam int MAX_BODY = 4096;
  localparam int LEN_W = $clog2(MAX_BODY + 1);
  localparam int SEQ_W = 2;
  localparam int EID_W = 8;
  localparam int TAG_W = 3;
  localparam int PLEN_W = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
  localparam logic [1:0] STATUS_OTHER = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELF_EID = 4'd0,
    CFG_EXPECT_RESPONSE = 4'd1,
    CFG_EXPECTED_EID = 4'd2,
    CFG_EXPECTED_TAG = 4'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    OUT_APPENDED = 4'd0,
    OUT_COMPLETE = 4'd1,
    OUT_IGNORED = 4'd2,
    OUT_UNEXPECTED = 4'd3,
    OUT_INVALID = 4'd4,
    OUT_CHECKSUM = 4'd5,
    OUT_OUT_OF_ORDER = 4'd6,
    OUT_SEQUENCE = 4'd7,
    OUT_TAG_MISMATCH = 4'd8,
    OUT_BAD_LENGTH = 4'd9,
    OUT_OVERFLOW = 4'd10,
    OUT_DROPPED = 4'd11
  } outcome_t;

  typedef struct packed {
    logic [1:0] parse_status;
    logic start_of_message;
    logic end_of_message;
    logic [EID_W-1:0] src_eid;
    logic [EID_W-1:0] dst_eid;
    logic [TAG_W-1:0] msg_tag;
    logic [SEQ_W-1:0] seq_num;
    logic is_request;
    logic [PLEN_W-1:0] payload_length;
  } pkt_t;

  typedef struct packed {
    outcome_t outcome;
    logic send_error_response;
    logic [LEN_W-1:0] write_offset;
    logic [LEN_W-1:0] message_length;
  } res_t;

  typedef struct packed {
    logic [EID_W-1:0] self_eid;
    logic expect_response;
    logic [EID_W-1:0] expected_eid;
    logic [TAG_W-1:0] expected_tag;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0] assembled_length;
    logic [PLEN_W-1:0] first_packet_length;
    logic [SEQ_W-1:0] expected_seq;
    logic [TAG_W-1:0] current_tag;
    logic [EID_W-1:0] current_source;
  } asm_state_t;

endpackage

// ===== sv/mprc_cfg.sv =====
module mprc_cfg import mprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  resp_done,
  output cfg_t                  cfg
);

  cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SELF_EID:        cfg_next.self_eid = cfg_data[EID_W-1:0];
        CFG_EXPECT_RESPONSE: cfg_next.expect_response = cfg_data[0];
        CFG_EXPECTED_EID:    cfg_next.expected_eid = cfg_data[EID_W-1:0];
        CFG_EXPECTED_TAG:    cfg_next.expected_tag = cfg_data[TAG_W-1:0];
        default:             cfg_next = cfg;
      endcase
    end else if (resp_done) begin
      cfg_next.expect_response = 1'b0;
      cfg_next.expected_tag = cfg.expected_tag + TAG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== sv/mprc_check.sv =====
module mprc_check import mprc_pkg::*; (
  input  pkt_t       pkt,
  input  cfg_t       cfg,
  input  asm_state_t st,
  output res_t       res,
  output asm_state_t st_next,
  output logic       resp_done
);

  logic       request;
  logic       err_due;
  logic       has_err;
  logic       early;
  outcome_t   code;
  asm_state_t base;
  logic [LEN_W:0] sum;
  logic [LEN_W-1:0] new_len;

  assign request = pkt.is_request;
  assign err_due = (pkt.dst_eid == cfg.self_eid) && request;

  always_comb begin
    has_err = 1'b0;
    early = 1'b0;
    code = OUT_APPENDED;
    base = st;
    priority if (pkt.parse_status != STATUS_OK) begin
      has_err = 1'b1;
      code = (pkt.parse_status == STATUS_INVALID) ? OUT_INVALID : OUT_CHECKSUM;
    end else if (pkt.dst_eid != cfg.self_eid && pkt.dst_eid != '0) begin
      early = 1'b1;
      code = OUT_IGNORED;
    end else if (!request && (!cfg.expect_response || pkt.src_eid != cfg.expected_eid
                              || pkt.msg_tag != cfg.expected_tag)) begin
      early = 1'b1;
      code = OUT_UNEXPECTED;
    end else if (pkt.start_of_message) begin
      base.assembled_length = '0;
      base.first_packet_length = pkt.payload_length;
      base.expected_seq = '0;
      base.current_tag = pkt.msg_tag;
      base.current_source = pkt.src_eid;
    end else if (st.first_packet_length == '0) begin
      has_err = 1'b1;
      code = OUT_OUT_OF_ORDER;
    end else if (pkt.seq_num != st.expected_seq) begin
      has_err = 1'b1;
      code = OUT_SEQUENCE;
    end else if (pkt.msg_tag != st.current_tag) begin
      has_err = 1'b1;
      code = OUT_TAG_MISMATCH;
    end else if (pkt.src_eid != st.current_source) begin
      early = 1'b1;
      code = OUT_IGNORED;
    end else if (pkt.payload_length != st.first_packet_length
                 && !(pkt.end_of_message && pkt.payload_length < st.first_packet_length)) begin
      has_err = 1'b1;
      code = OUT_BAD_LENGTH;
    end else begin
      code = OUT_APPENDED;
    end

    sum = {1'b0, base.assembled_length} + (LEN_W + 1)'(pkt.payload_length);
    new_len = sum[LEN_W-1:0];
    if (!has_err && !early && sum > (LEN_W + 1)'(MAX_BODY)) begin
      has_err = 1'b1;
      code = OUT_OVERFLOW;
    end

    st_next = st;
    resp_done = 1'b0;
    res = '{outcome: code, send_error_response: 1'b0, write_offset: '0, message_length: '0};

    priority if (pkt.parse_status == STATUS_OTHER) begin
      st_next.assembled_length = '0;
      st_next.first_packet_length = '0;
      res.outcome = OUT_DROPPED;
    end else if (early) begin
      st_next = st;
    end else if (has_err) begin
      st_next = base;
      if (err_due) begin
        st_next.assembled_length = '0;
        st_next.first_packet_length = '0;
      end
      res.send_error_response = err_due;
    end else begin
      st_next = base;
      st_next.expected_seq = base.expected_seq + SEQ_W'(1);
      res.write_offset = base.assembled_length;
      if (pkt.end_of_message) begin
        st_next.assembled_length = '0;
        st_next.first_packet_length = '0;
        resp_done = !request;
        res.outcome = OUT_COMPLETE;
        res.message_length = new_len;
      end else begin
        st_next.assembled_length = new_len;
      end
    end
  end

endmodule

// ===== sv/mctp_packet_reassembly_checker.sv =====
// Channel  Handshake                Payload
// pkt      pkt_valid / pkt_ready    pkt (pkt_t), one parsed packet header
// res      res_valid / res_ready    res (res_t), one result per packet
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data; always ready
//
// A header is registered in the input register on acceptance, checked against the
// reassembly state and its result registered in the result register. The state update
// happens as the header moves to the result register, which sustains one header per
// cycle while results are taken. A stalled result holds the input register; the input
// side stays ready as long as the input register can move on.
// Reset is synchronous and clears the configuration and the reassembly state.
module mctp_packet_reassembly_checker import mprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pkt_valid,
  output logic                  pkt_ready,
  input  pkt_t                  pkt,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  asm_state_t st;
  asm_state_t st_next;
  res_t       check_res;
  logic       check_resp_done;
  logic       hold_valid;
  pkt_t       hold;
  logic       advance;

  assign advance = hold_valid && (!res_valid || res_ready);
  assign pkt_ready = !hold_valid || advance;

  mprc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .resp_done (advance && check_resp_done),
    .cfg       (cfg)
  );

  mprc_check u_check (
    .pkt       (hold),
    .cfg       (cfg),
    .st        (st),
    .res       (check_res),
    .st_next   (st_next),
    .resp_done (check_resp_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      res_valid <= 1'b0;
      st <= '0;
    end else begin
      if (pkt_ready) begin
        hold_valid <= pkt_valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
        st <= st_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      hold <= pkt;
    end
    if (advance) begin
      res <= check_res;
    end
  end

endmodule

// ===== tb/sv/mprc_result_checker.sv =====
`timescale 1ns / 100ps

module mprc_result_checker import mprc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pkt_valid,
  input  logic                  pkt_ready,
  input  pkt_t                  pkt,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  res_t                  res,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding,
  output int                    completed,
  output int                    error_responses
);

  cfg_t       regs;
  asm_state_t asm_st;
  res_t       due_results[$];
  int         fails;
  int         done_msgs;
  int         err_resps;

  function automatic void clear_assembly();
    asm_st.assembled_length = '0;
    asm_st.first_packet_length = '0;
  endfunction

  // Works out the result of one header and advances the reassembly state.
  function automatic res_t judge_header(pkt_t p);
    res_t r;
    logic err_due;
    logic fault;
    int   total;
    r = '0;
    r.outcome = OUT_APPENDED;
    fault = 1'b0;
    err_due = (p.dst_eid == regs.self_eid) && p.is_request;
    if (p.parse_status == STATUS_OTHER) begin
      clear_assembly();
      r.outcome = OUT_DROPPED;
      return r;
    end
    if (p.parse_status != STATUS_OK) begin
      fault = 1'b1;
      r.outcome = (p.parse_status == STATUS_INVALID) ? OUT_INVALID : OUT_CHECKSUM;
    end else if (p.dst_eid != regs.self_eid && p.dst_eid != '0) begin
      r.outcome = OUT_IGNORED;
      return r;
    end else if (!p.is_request && (!regs.expect_response ||
                 p.src_eid != regs.expected_eid || p.msg_tag != regs.expected_tag)) begin
      r.outcome = OUT_UNEXPECTED;
      return r;
    end else if (p.start_of_message) begin
      asm_st.assembled_length = '0;
      asm_st.first_packet_length = p.payload_length;
      asm_st.expected_seq = '0;
      asm_st.current_tag = p.msg_tag;
      asm_st.current_source = p.src_eid;
    end else if (asm_st.first_packet_length == '0) begin
      fault = 1'b1;
      r.outcome = OUT_OUT_OF_ORDER;
    end else if (p.seq_num != asm_st.expected_seq) begin
      fault = 1'b1;
      r.outcome = OUT_SEQUENCE;
    end else if (p.msg_tag != asm_st.current_tag) begin
      fault = 1'b1;
      r.outcome = OUT_TAG_MISMATCH;
    end else if (p.src_eid != asm_st.current_source) begin
      r.outcome = OUT_IGNORED;
      return r;
    end else if (p.payload_length != asm_st.first_packet_length &&
                 !(p.end_of_message && p.payload_length < asm_st.first_packet_length)) begin
      fault = 1'b1;
      r.outcome = OUT_BAD_LENGTH;
    end
    total = int'(p.payload_length) + int'(asm_st.assembled_length);
    if (!fault && total > MAX_BODY) begin
      fault = 1'b1;
      r.outcome = OUT_OVERFLOW;
    end
    if (fault) begin
      if (err_due) begin
        clear_assembly();
      end
      r.send_error_response = err_due;
      return r;
    end
    r.write_offset = asm_st.assembled_length;
    asm_st.assembled_length = asm_st.assembled_length + LEN_W'(p.payload_length);
    asm_st.expected_seq = asm_st.expected_seq + SEQ_W'(1);
    if (p.end_of_message) begin
      r.outcome = OUT_COMPLETE;
      r.message_length = asm_st.assembled_length;
      clear_assembly();
      if (!p.is_request) begin
        regs.expect_response = 1'b0;
        regs.expected_tag = regs.expected_tag + TAG_W'(1);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      regs = '0;
      asm_st = '0;
      due_results.delete();
      fails = 0;
      done_msgs = 0;
      err_resps = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_SELF_EID:        regs.self_eid = cfg_data;
          CFG_EXPECT_RESPONSE: regs.expect_response = cfg_data[0];
          CFG_EXPECTED_EID:    regs.expected_eid = cfg_data;
          CFG_EXPECTED_TAG:    regs.expected_tag = cfg_data[TAG_W-1:0];
          default: ;
        endcase
      end
      if (pkt_valid && pkt_ready) begin
        due_results.push_back(judge_header(pkt));
      end
      if (res_valid && res_ready) begin
        if (due_results.size() == 0) begin
          fails++;
          $error("result transaction with no packet outstanding: outcome %0d", res.outcome);
        end else begin
          want = due_results.pop_front();
          if (want.outcome == OUT_COMPLETE) done_msgs++;
          if (want.send_error_response) err_resps++;
          if (res.outcome !== want.outcome) begin
            fails++;
            $error("outcome: expected %0d, actual %0d", want.outcome, res.outcome);
          end
          if (res.send_error_response !== want.send_error_response) begin
            fails++;
            $error("send_error_response: expected %0d, actual %0d",
                   want.send_error_response, res.send_error_response);
          end
          if (res.write_offset !== want.write_offset) begin
            fails++;
            $error("write_offset: expected %0d, actual %0d", want.write_offset,
                   res.write_offset);
          end
          if (res.message_length !== want.message_length) begin
            fails++;
            $error("message_length: expected %0d, actual %0d", want.message_length,
                   res.message_length);
          end
        end
      end
    end
    mismatches <= fails;
    outstanding <= due_results.size();
    completed <= done_msgs;
    error_responses <= err_resps;
  end

endmodule

// ===== tb/sv/tb_mctp_packet_reassembly_checker.sv =====
`timescale 1ns / 100ps

module tb_mctp_packet_reassembly_checker;
  import mprc_pkg::*;

  localparam int NBLOCKS = 40;
  localparam int BLOCK_ITEMS = 40;
  localparam int HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  pkt_valid;
  logic                  pkt_ready;
  pkt_t                  pkt;
  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   mismatches;
  int   outstanding;
  int   completed;
  int   error_responses;
  int   snd_idle = 0;
  int   rcv_stall = 0;
  bit   hold_req = 1'b0;
  int   items_sent = 0;
  int   quiet = 0;
  cfg_t cur_cfg;

  mctp_packet_reassembly_checker dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mprc_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .pkt_valid       (pkt_valid),
    .pkt_ready       (pkt_ready),
    .pkt             (pkt),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .completed       (completed),
    .error_responses (error_responses)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((pkt_valid && pkt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver either stalls at random or, on request, holds off for a long stretch.
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ready <= ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  function automatic pkt_t mk(logic [1:0] status, logic som, logic eom, logic [7:0] src,
                              logic [7:0] dst, logic [2:0] tag, logic [1:0] seq,
                              logic owner, logic [7:0] plen);
    pkt_t p;
    p.parse_status = status;
    p.start_of_message = som;
    p.end_of_message = eom;
    p.src_eid = src;
    p.dst_eid = dst;
    p.msg_tag = tag;
    p.seq_num = seq;
    p.is_request = owner;
    p.payload_length = plen;
    return p;
  endfunction

  function automatic logic [7:0] pick_eid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_dst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return cur_cfg.self_eid;
    if (r < 90) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic offer(pkt_t p);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(0, 99) < snd_idle) gap++;
    if (gap > 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt <= p;
    pkt_valid <= 1'b1;
    @(posedge clk);
    while (!pkt_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(CFG_SELF_EID, c.self_eid);
    write_reg(CFG_EXPECT_RESPONSE, CFG_DATA_W'(c.expect_response));
    write_reg(CFG_EXPECTED_EID, c.expected_eid);
    write_reg(CFG_EXPECTED_TAG, CFG_DATA_W'(c.expected_tag));
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic settle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_message(int npk, logic [7:0] plen, logic owner, logic [7:0] dst,
                              logic [7:0] src, logic [2:0] tag, int fault_pct);
    pkt_t p;
    logic last;
    for (int i = 0; i < npk; i++) begin
      last = (i == npk - 1);
      p = mk(STATUS_OK, i == 0, last, src, dst, tag, 2'(i), owner,
             (last && i > 0) ? 8'($urandom_range(0, plen)) : plen);
      if ($urandom_range(0, 99) < fault_pct) begin
        case ($urandom_range(0, 6))
          0: p.parse_status = 2'($urandom_range(1, 3));
          1: p.start_of_message = ~p.start_of_message;
          2: p.seq_num = p.seq_num + 2'($urandom_range(1, 3));
          3: p.msg_tag = p.msg_tag ^ 3'($urandom_range(1, 7));
          4: p.src_eid = 8'($urandom);
          5: p.payload_length = 8'($urandom);
          default: p.end_of_message = ~p.end_of_message;
        endcase
      end
      offer(p);
    end
  endtask

  task automatic run_block(int n);
    cfg_t c;
    int base;
    int r;
    logic [7:0] len;
    c.self_eid = pick_eid();
    c.expect_response = 1'($urandom_range(0, 1));
    c.expected_eid = pick_eid();
    c.expected_tag = 3'($urandom_range(0, 7));
    settle();
    program_regs(c);
    base = items_sent;
    if (c.expect_response && $urandom_range(0, 2) != 0) begin
      send_message($urandom_range(1, 5), 8'($urandom_range(1, 255)), 1'b0, pick_dst(),
                   c.expected_eid, c.expected_tag, 10);
    end
    while (items_sent - base < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        offer(pkt_t'($urandom));
      end else if (r < 16) begin
        send_message(18, 8'($urandom_range(240, 255)), 1'b1, pick_dst(), 8'($urandom),
                     3'($urandom), 0);
      end else begin
        r = $urandom_range(0, 19);
        len = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(1, 255));
        if ($urandom_range(0, 9) == 0) begin
          send_message($urandom_range(1, 7), len, 1'b0, pick_dst(), cur_cfg.expected_eid,
                       cur_cfg.expected_tag, 15);
        end else begin
          send_message($urandom_range(1, 7), len, 1'b1, pick_dst(), 8'($urandom),
                       3'($urandom), 15);
        end
      end
    end
    pkt_valid <= 1'b0;
  endtask

  initial begin
    cfg_t c;
    rst <= 1'b1;
    pkt_valid <= 1'b0;
    pkt <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    c.self_eid = 8'h42;
    c.expect_response = 1'b1;
    c.expected_eid = 8'h10;
    c.expected_tag = 3'd5;
    program_regs(c);
    offer(mk(STATUS_OTHER, 1'b1, 1'b1, 8'hff, 8'hff, 3'd7, 2'd3, 1'b1, 8'hff));
    offer(mk(STATUS_INVALID, 1'b0, 1'b0, 8'h20, 8'h42, 3'd0, 2'd0, 1'b1, 8'd10));
    offer(mk(STATUS_CHECKSUM, 1'b1, 1'b0, 8'h20, 8'h00, 3'd0, 2'd0, 1'b1, 8'd10));
    offer(mk(STATUS_OK, 1'b1, 1'b0, 8'h20, 8'h43, 3'd0, 2'd0, 1'b1, 8'd10));
    offer(mk(STATUS_OK, 1'b1, 1'b1, 8'h11, 8'h42, 3'd5, 2'd0, 1'b0, 8'd10));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h20, 8'h42, 3'd2, 2'd1, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b1, 1'b0, 8'h20, 8'h42, 3'd2, 2'd0, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h20, 8'h42, 3'd2, 2'd1, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h20, 8'h42, 3'd2, 2'd3, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b1, 1'b0, 8'h20, 8'h00, 3'd2, 2'd0, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h20, 8'h00, 3'd3, 2'd1, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h21, 8'h00, 3'd2, 2'd1, 1'b1, 8'd64));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h20, 8'h00, 3'd2, 2'd1, 1'b1, 8'd32));
    offer(mk(STATUS_OK, 1'b0, 1'b1, 8'h20, 8'h00, 3'd2, 2'd1, 1'b1, 8'd32));
    offer(mk(STATUS_OK, 1'b1, 1'b0, 8'h20, 8'h42, 3'd1, 2'd0, 1'b1, 8'd0));
    offer(mk(STATUS_OK, 1'b0, 1'b1, 8'h20, 8'h42, 3'd1, 2'd1, 1'b1, 8'd0));
    offer(mk(STATUS_OK, 1'b1, 1'b0, 8'h10, 8'h42, 3'd5, 2'd0, 1'b0, 8'hff));
    offer(mk(STATUS_OK, 1'b0, 1'b1, 8'h10, 8'h42, 3'd5, 2'd1, 1'b0, 8'hff));
    offer(mk(STATUS_OK, 1'b1, 1'b1, 8'h10, 8'h42, 3'd5, 2'd0, 1'b0, 8'd1));
    offer(mk(STATUS_OK, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0, 2'd0, 1'b0, 8'd0));
    offer(mk(STATUS_OK, 1'b1, 1'b1, 8'h20, 8'h42, 3'd7, 2'd0, 1'b1, 8'hff));
    pkt_valid <= 1'b0;

    for (int blk = 0; blk < NBLOCKS; blk++) begin
      case (blk * 4 / NBLOCKS)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 81; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 81; end
        default: begin snd_idle = 36; rcv_stall = 36; end
      endcase
      if (blk == 3) begin
        fork
          begin
            repeat (20) @(posedge clk);
            hold_req = 1'b1;
          end
        join_none
      end
      run_block(BLOCK_ITEMS);
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Ran %0d packet headers over %0d register settings and four pacing modes.",
             items_sent, NBLOCKS + 1);
    $display("%0d messages completed and %0d error responses flagged.", completed,
             error_responses);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
